// ----- rtl/ansu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansu_pkg
// Types and constants shared by the Annex-B unit splitter modules.
// ----------------------------------------------------------------------------
package ansu_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_OUT_W  = 24;
  localparam int WIN_DEPTH  = 4;
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
  localparam int VIEW_BYTES = WIN_DEPTH + 1;
  localparam int AVAIL_W    = $clog2(VIEW_BYTES + 1);
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OQ_DEPTH   = 2;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;

  // bytes of a start code still to pass after its first byte
  localparam logic [1:0] SKIP_LONG_CODE  = 2'd3;
  localparam logic [1:0] SKIP_SHORT_CODE = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                           is_end;
    logic [FILL_W-1:0]              fill;
    logic [VIEW_BYTES-1:0][BYTE_W-1:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    out_byte;
    logic                 byte_valid;
    logic                 unit_first;
    logic                 unit_last;
    logic [LEN_OUT_W-1:0] unit_length;
    logic                 stream_end;
    logic                 run_last;
  } result_t;

endpackage

// ----- rtl/annexb_nal_unit_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex-B byte stream into start-code delimited units.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the command queue has room; each byte
// is decided once four later bytes arrive, so a byte beat gives at most one
// result and the block sustains one byte per cycle while results are popped.
// The decide back end handles one window position per cycle unless the
// output queue is full. An end beat flushes the held bytes one by one,
// ending with the end-of-stream result. A command queue of four entries and
// an output queue of two entries decouple input, decide unit and result side.
// Unit length counts in LENGTH_BITS bits, saturating, reported in 24 bits.
module annexb_nal_unit_splitter #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [ansu_pkg::BYTE_W-1:0]       in_byte_value,
  input  logic                              in_is_end,
  output logic                              empty,
  input  logic                              pop,
  output logic [ansu_pkg::BYTE_W-1:0]       out_out_byte,
  output logic                              out_byte_valid,
  output logic                              out_unit_first,
  output logic                              out_unit_last,
  output logic [ansu_pkg::LEN_OUT_W-1:0]    out_unit_length,
  output logic                              out_stream_end,
  output logic                              out_run_last
);
  import ansu_pkg::*;

  cmd_t    cmd_wr, cmd_rd;
  logic    cmd_push, cmd_pop, cmd_empty, cmd_full;
  result_t res_head;

  ansu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte_value (in_byte_value),
    .in_is_end     (in_is_end),
    .q_full        (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_wr)
  );

  ansu_cmd_queue u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty),
    .full    (cmd_full)
  );

  ansu_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_rd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_head  (res_head),
    .empty     (empty),
    .pop       (pop)
  );

  assign out_out_byte    = res_head.out_byte;
  assign out_byte_valid  = res_head.byte_valid;
  assign out_unit_first  = res_head.unit_first;
  assign out_unit_last   = res_head.unit_last;
  assign out_unit_length = res_head.unit_length;
  assign out_stream_end  = res_head.stream_end;
  assign out_run_last    = res_head.run_last;

endmodule

// ----- rtl/ansu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansu_front
// Lookahead window: takes input beats, fills the four-byte window and issues
// one decide command per byte once full, or a flush command at end of stream.
// ----------------------------------------------------------------------------
module ansu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  ansu_pkg::byte_t      in_byte_value,
  input  logic                 in_is_end,
  input  logic                 q_full,
  output logic                 cmd_push,
  output ansu_pkg::cmd_t       cmd_data
);
  import ansu_pkg::*;

  logic [WIN_DEPTH-1:0][BYTE_W-1:0] window_r, window_nxt;
  logic [FILL_W-1:0]                fill_r, fill_nxt;
  logic                             accept;

  assign full   = q_full;
  assign accept = push & ~q_full;

  always_comb begin
    cmd_push   = 1'b0;
    cmd_data   = '0;
    window_nxt = window_r;
    fill_nxt   = fill_r;
    if (accept) begin
      if (in_is_end) begin
        cmd_push        = 1'b1;
        cmd_data.is_end = 1'b1;
        cmd_data.fill   = fill_r;
        for (int i = 0; i < WIN_DEPTH; i++) begin
          cmd_data.bytes[i] = window_r[i];
        end
        window_nxt = '0;
        fill_nxt   = '0;
      end else if (fill_r < FILL_W'(WIN_DEPTH)) begin
        window_nxt[fill_r[WIN_IDX_W-1:0]] = in_byte_value;
        fill_nxt = fill_r + 1'b1;
      end else begin
        cmd_push = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
          cmd_data.bytes[i] = window_r[i];
        end
        cmd_data.bytes[WIN_DEPTH] = in_byte_value;
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          window_nxt[i] = window_r[i+1];
        end
        window_nxt[WIN_DEPTH-1] = in_byte_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
    end else begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ----- rtl/ansu_cmd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansu_cmd_queue
// Short command queue between the window front and the decide back end.
// ----------------------------------------------------------------------------
module ansu_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ansu_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output ansu_pkg::cmd_t rd_data,
  output logic           empty,
  output logic           full
);
  import ansu_pkg::*;

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  do_wr, do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/ansu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansu_back
// Decide unit: tracks unit state, marks first and last bytes, counts unit
// length and walks the held bytes on a flush; results go to a two-beat queue.
// ----------------------------------------------------------------------------
module ansu_back #(
  parameter int LENGTH_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ansu_pkg::cmd_t    cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output ansu_pkg::result_t res_head,
  output logic              empty,
  input  logic              pop
);
  import ansu_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic                   inside_r, inside_nxt;
  logic [1:0]             skip_r, skip_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt, len_base;
  logic [FILL_W-1:0]      pos_r, pos_nxt;

  result_t                oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]    oq_wr_r, oq_rd_r;
  logic [OQ_CNT_W-1:0]    oq_cnt_r;
  logic                   oq_full, oq_push, oq_pop;

  logic                   step, flush_done, has_res, code4, code3, last;
  logic [AVAIL_W-1:0]     n, avail;
  logic [FILL_W-1:0]      p;
  logic [VIEW_BYTES-1:0][BYTE_W-1:0] w;
  result_t                res;

  assign oq_full    = (oq_cnt_r == OQ_CNT_W'(OQ_DEPTH));
  assign step       = ~cmd_empty & ~oq_full;
  assign flush_done = cmd.is_end & (pos_r == cmd.fill);
  assign p          = cmd.is_end ? pos_r : '0;
  assign n          = cmd.is_end ? AVAIL_W'(cmd.fill) : AVAIL_W'(VIEW_BYTES);
  assign avail      = n - AVAIL_W'(p);
  assign w          = cmd.bytes >> {p, 3'b000};

  assign code4 = (avail >= AVAIL_W'(4)) && (w[0] == SC_ZERO) && (w[1] == SC_ZERO)
                 && (w[2] == SC_ZERO) && (w[3] == SC_ONE);
  assign code3 = (avail >= AVAIL_W'(3)) && (w[0] == SC_ZERO) && (w[1] == SC_ZERO)
                 && (w[2] == SC_ONE);

  always_comb begin
    inside_nxt = inside_r;
    skip_nxt   = skip_r;
    len_nxt    = len_r;
    len_base   = len_r;
    pos_nxt    = pos_r;
    has_res    = 1'b0;
    last       = 1'b0;
    res        = '0;
    if (flush_done) begin
      has_res        = 1'b1;
      res.stream_end = 1'b1;
      res.run_last   = 1'b1;
      inside_nxt     = 1'b0;
      skip_nxt       = '0;
      len_nxt        = '0;
      pos_nxt        = '0;
    end else begin
      if (cmd.is_end) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (!inside_r) begin
        if (code4 || code3) begin
          has_res        = 1'b1;
          inside_nxt     = 1'b1;
          skip_nxt       = code4 ? SKIP_LONG_CODE : SKIP_SHORT_CODE;
          len_base       = '0;
          res.unit_first = 1'b1;
        end
      end else begin
        has_res = 1'b1;
        if (skip_r != '0) begin
          skip_nxt = skip_r - 1'b1;
        end
      end
      if (has_res) begin
        len_nxt = (len_base != LEN_MAX) ? len_base + 1'b1 : len_base;
        if (avail == AVAIL_W'(1)) begin
          last = 1'b1;
        end else if (skip_nxt == '0) begin
          last = (avail >= AVAIL_W'(4)) && (w[1] == SC_ZERO) && (w[2] == SC_ZERO)
                 && ((w[3] == SC_ONE) || ((avail >= AVAIL_W'(5)) && (w[3] == SC_ZERO)
                 && (w[4] == SC_ONE)));
        end
        if (last) begin
          inside_nxt      = 1'b0;
          skip_nxt        = '0;
          res.unit_length = LEN_OUT_W'(len_nxt);
        end
        res.out_byte   = w[0];
        res.byte_valid = 1'b1;
        res.unit_last  = last;
        res.run_last   = ~cmd.is_end;
      end
    end
  end

  assign cmd_pop  = step & (~cmd.is_end | flush_done);
  assign oq_push  = step & has_res;
  assign oq_pop   = pop & ~empty;
  assign empty    = (oq_cnt_r == '0);
  assign res_head = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      skip_r   <= '0;
      len_r    <= '0;
      pos_r    <= '0;
    end else if (step) begin
      inside_r <= inside_nxt;
      skip_r   <= skip_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      unique case ({oq_push, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + 1'b1;
        2'b01:   oq_cnt_r <= oq_cnt_r - 1'b1;
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/ansu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansu_checker
// Port-level checks on the result side of the unit splitter.
// ----------------------------------------------------------------------------
module ansu_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           empty,
  input logic                           pop,
  input logic [ansu_pkg::BYTE_W-1:0]    out_out_byte,
  input logic                           out_byte_valid,
  input logic                           out_unit_first,
  input logic                           out_unit_last,
  input logic [ansu_pkg::LEN_OUT_W-1:0] out_unit_length,
  input logic                           out_stream_end,
  input logic                           out_run_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_out_byte) && $stable(out_unit_length)))
    else $error("stalled beat changed");

  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_stream_end) |-> (out_run_last && !out_byte_valid && !out_unit_first))
    else $error("malformed end-of-stream beat");

  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_unit_last) |-> (out_unit_length == '0))
    else $error("unit length outside last byte");

  a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_unit_last) |-> (out_byte_valid && out_unit_length != '0))
    else $error("last byte without length");

endmodule

bind annexb_nal_unit_splitter ansu_checker u_ansu_checker (.*);
